// ===== src/tlvfx_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvfx_pkg: shared types and constants for the TLV field extractor
// Parse phase codes, the parse state record and register map.
// ----------------------------------------------------------------------------
package tlvfx_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [7:0] ExtFlag    = 8'h80;
  localparam logic [7:0] ExtCntMask = 8'h7f;
  localparam logic [6:0] MaxExtCnt  = 7'd4;

  // word index of each configuration register
  localparam logic RegMatchType = 1'b0;
  localparam logic RegEndType   = 1'b1;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_LEN    = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [2:0]          ext_left;
    logic [ValueW-1:0]   remaining;
    logic                opt_hit;
    logic [ValueW-1:0]   accum;
    logic                found;
  } parse_state_t;

  localparam parse_state_t ParseReset = '{
    phase:     PH_TYPE,
    ext_left:  3'd0,
    remaining: '0,
    opt_hit:   1'b0,
    accum:     '0,
    found:     1'b0
  };

endpackage

// ===== src/tlvfx_step.sv =====
// ----------------------------------------------------------------------------
// tlvfx_step: per-byte parse state update
// Computes the next parse state from the current state and one packet byte.
// ----------------------------------------------------------------------------
module tlvfx_step (
  input  tlvfx_pkg::parse_state_t cur_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    last_byte_i,
  input  logic [7:0]              match_type_i,
  input  logic [7:0]              end_type_i,
  output tlvfx_pkg::parse_state_t nxt_o
);

  logic [6:0]  ext_cnt;
  logic [31:0] ext_len;
  logic [2:0]  ext_left_dec;
  logic [31:0] rem_dec;
  logic [31:0] len_sel;
  logic        len_valid;

  assign ext_cnt      = data_byte_i[6:0] & tlvfx_pkg::ExtCntMask[6:0];
  assign ext_len      = {cur_i.remaining[23:0], data_byte_i};
  assign ext_left_dec = cur_i.ext_left - 3'd1;
  assign rem_dec      = cur_i.remaining - 32'd1;

  always_comb begin
    nxt_o     = cur_i;
    len_sel   = '0;
    len_valid = 1'b0;

    unique case (cur_i.phase)
      tlvfx_pkg::PH_TYPE: begin
        if (last_byte_i || (data_byte_i == end_type_i)) begin
          nxt_o.phase = tlvfx_pkg::PH_DONE;
        end else begin
          nxt_o.opt_hit = (data_byte_i == match_type_i);
          nxt_o.phase   = tlvfx_pkg::PH_LEN;
        end
      end
      tlvfx_pkg::PH_LEN: begin
        if ((data_byte_i & tlvfx_pkg::ExtFlag) != 8'd0) begin
          if (ext_cnt > tlvfx_pkg::MaxExtCnt) begin
            nxt_o.phase = tlvfx_pkg::PH_DONE;
          end else if (ext_cnt == 7'd0) begin
            len_valid = 1'b1;
          end else begin
            nxt_o.ext_left  = ext_cnt[2:0];
            nxt_o.remaining = '0;
            nxt_o.phase     = tlvfx_pkg::PH_EXTLEN;
          end
        end else begin
          len_sel   = {24'd0, data_byte_i};
          len_valid = 1'b1;
        end
      end
      tlvfx_pkg::PH_EXTLEN: begin
        nxt_o.remaining = ext_len;
        nxt_o.ext_left  = ext_left_dec;
        if (ext_left_dec == 3'd0) begin
          len_sel   = ext_len;
          len_valid = 1'b1;
        end
      end
      tlvfx_pkg::PH_VALUE: begin
        if (cur_i.opt_hit) begin
          nxt_o.accum = {cur_i.accum[23:0], data_byte_i};
        end
        nxt_o.remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          if (cur_i.opt_hit) begin
            nxt_o.found = 1'b1;
            nxt_o.phase = tlvfx_pkg::PH_DONE;
          end else begin
            nxt_o.phase = tlvfx_pkg::PH_TYPE;
          end
        end
      end
      default: begin
        // done: ignore bytes until the packet ends
      end
    endcase

    // full length known: start the value or close the option
    if (len_valid) begin
      nxt_o.accum = '0;
      if (len_sel == 32'd0) begin
        if (cur_i.opt_hit) begin
          nxt_o.found = 1'b1;
          nxt_o.phase = tlvfx_pkg::PH_DONE;
        end else begin
          nxt_o.phase = tlvfx_pkg::PH_TYPE;
        end
      end else begin
        nxt_o.remaining = len_sel;
        nxt_o.phase     = tlvfx_pkg::PH_VALUE;
      end
    end
  end

endmodule

// ===== src/tlv_field_extractor.sv =====
// ----------------------------------------------------------------------------
// tlv_field_extractor: streaming TLV option value extractor
// Scans packet bytes and reports the value of the first matching option.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one packet byte per beat (data_byte_i, last_byte_i) on
//   in_valid_i / in_ready_o. Bytes may arrive every cycle while in_ready_o is
//   high; each accepted beat updates the parse state register.
//   Output channel: one beat per packet (found_o, field_value_o) on
//   out_valid_o / out_ready_i, presented the cycle after the packet's last
//   byte is accepted. Throughput is one byte per cycle while in_ready_o is high.
//   The result sits in an output register; while it waits, a new byte is
//   still taken in the same cycle the receiver takes the result. When the
//   receiver stalls, in_ready_o drops only while a result is pending and
//   not being taken.
//   Configuration: match_type at 0x0, end_type at 0x4 over the APB port;
//   write only between packets.
//   Reset clears the parse state, both registers and the output register.
// ----------------------------------------------------------------------------
module tlv_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] field_value_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [tlvfx_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tlvfx_pkg::parse_state_t state_q, state_d, step_nxt;

  logic [7:0]  match_type_q, end_type_q;
  logic        out_valid_q, out_valid_d;
  logic        found_q, found_d;
  logic [31:0] value_q, value_d;
  logic        in_acc;
  logic        cfg_wr;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      tlvfx_pkg::RegMatchType: prdata = {24'd0, match_type_q};
      tlvfx_pkg::RegEndType:   prdata = {24'd0, end_type_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_type_q <= 8'd0;
      end_type_q   <= 8'd0;
    end else if (cfg_wr) begin
      if (reg_idx == tlvfx_pkg::RegMatchType) begin
        match_type_q <= pwdata[7:0];
      end else begin
        end_type_q <= pwdata[7:0];
      end
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  tlvfx_step u_step (
    .cur_i        (state_q),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .match_type_i (match_type_q),
    .end_type_i   (end_type_q),
    .nxt_o        (step_nxt)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    value_d     = value_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      if (last_byte_i) begin
        // close the packet: load the result, restart the parse
        out_valid_d = 1'b1;
        found_d     = step_nxt.found;
        value_d     = step_nxt.found ? step_nxt.accum : 32'd0;
        state_d     = tlvfx_pkg::ParseReset;
      end else begin
        state_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlvfx_pkg::ParseReset;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      value_q     <= 32'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      value_q     <= value_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign field_value_o = value_q;

  a_last_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> out_valid_o
  ) else $error("no result after last byte");

  a_zero_when_missing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (field_value_o == 32'd0)
  ) else $error("nonzero value without match");

  a_restart_after_packet: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=>
      (state_q.phase == tlvfx_pkg::PH_TYPE) && !state_q.found
  ) else $error("parse state not cleared at packet end");

  a_extlen_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == tlvfx_pkg::PH_EXTLEN) |-> (state_q.ext_left != 3'd0)
  ) else $error("extended length phase with zero count");

endmodule
